@@ rtl/core/priority_scheduler_with_aging_assert.svh @@
// Assertion macros used by the scheduler controller (psa_ctrl).
// Needs a clk and an arst_n in the scope where a macro is used.
`ifndef PRIORITY_SCHEDULER_WITH_AGING_ASSERT_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_ASSERT_SVH

// Property that holds in the same cycle (or any implication written inline).
`define PSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies another in the next cycle.
`define PSA_ASSERT_NEXT(lbl, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (nxt)) \
		else $error("next-cycle check failed");

`endif

@@ rtl/core/psa_pkg.sv @@
// Shared types and constants of the aging priority scheduler.
// No dependencies; used by psa_cell, psa_ctrl and the top level.
`timescale 1ns / 1ps
package psa_pkg;

	localparam int MAX_JOBS = 64;
	localparam int SLOT_W   = $clog2(MAX_JOBS);

	localparam logic [6:0] PRI_MAX     = 7'd99;
	localparam logic [6:0] PRI_MIN     = 7'd1;
	localparam logic [6:0] DEMOTE_STEP = 7'd20;

	localparam logic REQ_ARRIVAL = 1'b0;
	localparam logic REQ_TICK    = 1'b1;

	localparam logic [2:0] EV_ACCEPT = 3'd0;
	localparam logic [2:0] EV_REJECT = 3'd1;
	localparam logic [2:0] EV_RUN    = 3'd2;
	localparam logic [2:0] EV_TERM   = 3'd3;
	localparam logic [2:0] EV_DEMOTE = 3'd4;
	localparam logic [2:0] EV_IDLE   = 3'd5;

	localparam logic CFG_AGE_INTERVAL = 1'b0;
	localparam logic CFG_TIME_QUANTUM = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [15:0] job_id;
		logic [15:0] burst;
		logic [6:0]  priority_req;
		logic [6:0]  age_step;
	} req_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [15:0] job_id_res;
		logic [6:0]  new_priority;
		logic [31:0] tick;
		logic [31:0] turnaround;
		logic [31:0] wait_res;
		logic        last;
	} res_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_NEW,
		CMD_CLEAR,
		CMD_DEMOTE,
		CMD_START
	} cmd_op_t;

	// Broadcast from the controller to every cell.
	typedef struct packed {
		cmd_op_t           op;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       id;
		logic [6:0]        prio;
		logic [15:0]       remaining;
		logic [31:0]       arrival;
		logic [6:0]        step;
		logic              age_en;
		logic              run_valid;
		logic [SLOT_W-1:0] run_slot;
		logic [15:0]       interval;
	} cmd_t;

	// Best candidate so far, handed from cell to cell.
	typedef struct packed {
		logic              found;
		logic [6:0]        prio;
		logic [15:0]       id;
		logic [SLOT_W-1:0] slot;
		logic [15:0]       remaining;
		logic [15:0]       orig;
		logic [31:0]       arrival;
	} carry_t;

endpackage

@@ rtl/core/psa_cell.sv @@
// One job slot of the scheduler: holds the entry, ages it, and passes the
// running best candidate to the next cell. Depends on psa_pkg.
`timescale 1ns / 1ps
module psa_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [psa_pkg::SLOT_W-1:0] idx,
	input  psa_pkg::cmd_t              cmd,
	input  psa_pkg::carry_t            carry_in,
	output psa_pkg::carry_t            carry_out,
	output logic                       valid
);

	logic        valid_q;
	logic [15:0] id_q;
	logic [6:0]  prio_q;
	logic [15:0] age_q;
	logic [15:0] rem_q;
	logic [15:0] orig_q;
	logic [31:0] arr_q;
	logic [6:0]  step_q;
	psa_pkg::carry_t carry_q;

	logic        hit;
	logic        waiting;
	logic [15:0] age_inc;
	logic [7:0]  pri_sum;
	logic        take_own;

	assign hit     = (cmd.slot == idx);
	assign waiting = valid_q && !(cmd.run_valid && cmd.run_slot == idx);
	assign age_inc = age_q + 16'd1;
	assign pri_sum = {1'b0, prio_q} + {1'b0, step_q};

	assign take_own = valid_q && (!carry_in.found || prio_q > carry_in.prio ||
		(prio_q == carry_in.prio && id_q < carry_in.id));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q       <= 1'b0;
			carry_q.found <= 1'b0;
		end else begin
			if (take_own) begin
				carry_q <= '{found: 1'b1, prio: prio_q, id: id_q, slot: idx,
					remaining: rem_q, orig: orig_q, arrival: arr_q};
			end else begin
				carry_q <= carry_in;
			end
			if (hit) begin
				case (cmd.op)
					psa_pkg::CMD_NEW: begin
						valid_q <= 1'b1;
						id_q    <= cmd.id;
						prio_q  <= cmd.prio;
						age_q   <= '0;
						rem_q   <= cmd.remaining;
						orig_q  <= cmd.remaining;
						arr_q   <= cmd.arrival;
						step_q  <= cmd.step;
					end
					psa_pkg::CMD_CLEAR: valid_q <= 1'b0;
					psa_pkg::CMD_DEMOTE: begin
						prio_q <= cmd.prio;
						age_q  <= '0;
						rem_q  <= cmd.remaining;
					end
					psa_pkg::CMD_START: age_q <= '0;
					default: ;
				endcase
			end
			if (cmd.age_en && waiting) begin
				if (cmd.interval != '0 && age_inc == cmd.interval) begin
					age_q  <= '0;
					prio_q <= (pri_sum > {1'b0, psa_pkg::PRI_MAX}) ? psa_pkg::PRI_MAX
						: pri_sum[6:0];
				end else begin
					age_q <= age_inc;
				end
			end
		end
	end

	assign carry_out = carry_q;
	assign valid     = valid_q;

endmodule

@@ rtl/core/psa_ctrl.sv @@
// Sequencer of the scheduler: takes transactions, runs the tick steps,
// drives the cell commands and the output register. Depends on psa_pkg.
`timescale 1ns / 1ps
`include "priority_scheduler_with_aging_assert.svh"
module psa_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  psa_pkg::req_t                 in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output psa_pkg::res_t                 out_data,
	input  logic                          cfg_we,
	input  logic                          cfg_idx,
	input  logic [15:0]                   cfg_data,
	input  logic [psa_pkg::MAX_JOBS-1:0]  cell_valid,
	input  psa_pkg::carry_t               best,
	output psa_pkg::cmd_t                 cmd
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_RUN, ST_SCAN, ST_START, ST_AGE, ST_EMIT0, ST_EMIT1
	} state_t;

	state_t state_q;
	logic [15:0] age_interval_q, time_quantum_q;
	logic        run_valid_q;
	logic [psa_pkg::SLOT_W-1:0] run_slot_q;
	logic [15:0] run_id_q;
	logic [6:0]  run_prio_q;
	logic [15:0] run_rem_q, run_orig_q;
	logic [31:0] run_arr_q;
	logic [15:0] quantum_q;
	logic [31:0] tick_q;
	psa_pkg::res_t res_q [2];
	logic [1:0]  nres_q;
	logic [psa_pkg::SLOT_W-1:0] scan_q;
	logic        out_valid_q;
	psa_pkg::res_t out_q;

	logic        accept, out_free, req_ok, free_found, load_out;
	logic [psa_pkg::SLOT_W-1:0] free_slot;
	logic [15:0] rem_dec;
	logic [31:0] ta, wt;
	logic [6:0]  demoted;
	logic        do_term, do_demote;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign load_out = (state_q == ST_EMIT0 || state_q == ST_EMIT1) && out_free;
	assign req_ok   = in_data.burst != '0 && in_data.priority_req >= psa_pkg::PRI_MIN &&
		in_data.priority_req <= psa_pkg::PRI_MAX && in_data.age_step != '0;

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = psa_pkg::MAX_JOBS - 1; i >= 0; i--) begin
			if (!cell_valid[i]) begin
				free_found = 1'b1;
				free_slot  = psa_pkg::SLOT_W'(i);
			end
		end
	end

	assign rem_dec   = run_rem_q - 16'd1;
	assign ta        = tick_q - run_arr_q;
	assign wt        = ta - {16'd0, run_orig_q};
	assign demoted   = (run_prio_q > psa_pkg::DEMOTE_STEP + psa_pkg::PRI_MIN)
		? run_prio_q - psa_pkg::DEMOTE_STEP : psa_pkg::PRI_MIN;
	assign do_term   = run_valid_q && rem_dec == '0;
	assign do_demote = run_valid_q && !do_term && time_quantum_q != '0 &&
		quantum_q == time_quantum_q;

	always_comb begin
		cmd           = '0;
		cmd.op        = psa_pkg::CMD_NONE;
		cmd.run_valid = run_valid_q;
		cmd.run_slot  = run_slot_q;
		cmd.interval  = age_interval_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_data.req_type == psa_pkg::REQ_ARRIVAL && req_ok &&
					free_found) begin
					cmd.op        = psa_pkg::CMD_NEW;
					cmd.slot      = free_slot;
					cmd.id        = in_data.job_id;
					cmd.prio      = in_data.priority_req;
					cmd.remaining = in_data.burst;
					cmd.arrival   = tick_q;
					cmd.step      = in_data.age_step;
				end
			end
			ST_RUN: begin
				cmd.slot = run_slot_q;
				if (do_term) begin
					cmd.op = psa_pkg::CMD_CLEAR;
				end else if (do_demote) begin
					cmd.op        = psa_pkg::CMD_DEMOTE;
					cmd.prio      = demoted;
					cmd.remaining = rem_dec;
				end
			end
			ST_START: begin
				cmd.slot = best.slot;
				if (best.found) cmd.op = psa_pkg::CMD_START;
			end
			ST_AGE: cmd.age_en = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			age_interval_q <= 16'd10;
			time_quantum_q <= 16'd10;
			run_valid_q    <= 1'b0;
			run_slot_q     <= '0;
			quantum_q      <= '0;
			tick_q         <= '0;
			nres_q         <= '0;
			scan_q         <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					psa_pkg::CFG_AGE_INTERVAL: age_interval_q <= cfg_data;
					psa_pkg::CFG_TIME_QUANTUM: time_quantum_q <= cfg_data;
					default: ;
				endcase
			end
			if (load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (in_data.req_type == psa_pkg::REQ_ARRIVAL) begin
							res_q[0] <= '{event_res: (req_ok && free_found)
								? psa_pkg::EV_ACCEPT : psa_pkg::EV_REJECT,
								job_id_res: in_data.job_id,
								new_priority: (req_ok && free_found)
								? in_data.priority_req : 7'd0,
								tick: tick_q, turnaround: '0, wait_res: '0, last: 1'b1};
							nres_q  <= 2'd1;
							state_q <= ST_EMIT0;
						end else begin
							nres_q    <= '0;
							quantum_q <= quantum_q + 16'd1;
							state_q   <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					scan_q <= '0;
					if (run_valid_q) run_rem_q <= rem_dec;
					if (do_term) begin
						res_q[0] <= '{event_res: psa_pkg::EV_TERM, job_id_res: run_id_q,
							new_priority: 7'd0, tick: tick_q, turnaround: ta,
							wait_res: wt, last: 1'b0};
						nres_q      <= 2'd1;
						run_valid_q <= 1'b0;
						quantum_q   <= '0;
						state_q     <= ST_SCAN;
					end else if (do_demote) begin
						res_q[0] <= '{event_res: psa_pkg::EV_DEMOTE, job_id_res: run_id_q,
							new_priority: demoted, tick: tick_q, turnaround: '0,
							wait_res: '0, last: 1'b0};
						nres_q      <= 2'd1;
						run_valid_q <= 1'b0;
						quantum_q   <= '0;
						state_q     <= ST_SCAN;
					end else if (run_valid_q) begin
						state_q <= ST_AGE;
					end else begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// let the candidate ripple through every cell
					scan_q <= scan_q + 1'b1;
					if (scan_q == psa_pkg::SLOT_W'(psa_pkg::MAX_JOBS - 1)) state_q <= ST_START;
				end
				ST_START: begin
					if (best.found) begin
						run_valid_q <= 1'b1;
						run_slot_q  <= best.slot;
						run_id_q    <= best.id;
						run_prio_q  <= best.prio;
						run_rem_q   <= best.remaining;
						run_orig_q  <= best.orig;
						run_arr_q   <= best.arrival;
						quantum_q   <= '0;
						res_q[nres_q[0]] <= '{event_res: psa_pkg::EV_RUN,
							job_id_res: best.id, new_priority: best.prio, tick: tick_q,
							turnaround: '0, wait_res: '0, last: 1'b1};
						nres_q <= nres_q + 2'd1;
					end else if (nres_q == '0) begin
						res_q[0] <= '{event_res: psa_pkg::EV_IDLE, job_id_res: '0,
							new_priority: '0, tick: tick_q, turnaround: '0,
							wait_res: '0, last: 1'b1};
						nres_q <= 2'd1;
					end else begin
						res_q[0].last <= 1'b1;
					end
					state_q <= ST_AGE;
				end
				ST_AGE: begin
					tick_q  <= tick_q + 32'd1;
					state_q <= (nres_q == '0) ? ST_IDLE : ST_EMIT0;
				end
				ST_EMIT0: begin
					if (out_free) begin
						out_q   <= res_q[0];
						state_q <= (nres_q == 2'd2) ? ST_EMIT1 : ST_IDLE;
					end
				end
				ST_EMIT1: begin
					if (out_free) begin
						out_q   <= res_q[1];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`PSA_ASSERT(a_emit1_two, (state_q == ST_EMIT1) |-> (nres_q == 2'd2), "second result missing")
	`PSA_ASSERT(a_run_slot_live, (run_valid_q && state_q == ST_IDLE) |-> cell_valid[run_slot_q], "running slot empty")
	`PSA_ASSERT_NEXT(a_arrival_one, accept && in_data.req_type == psa_pkg::REQ_ARRIVAL, state_q == ST_EMIT0 && nres_q == 2'd1)

endmodule

@@ rtl/core/priority_scheduler_with_aging.sv @@
// Aging priority scheduler.
// Input channel (in_valid / in_stall / in_data): an arrival stores a job in
// the first free of MAX_JOBS slots and answers accepted or rejected; a tick
// advances the scheduler and answers with zero, one or two results
// (terminate or demote, then start; or an idle result).
// Output channel (out_valid / out_stall / out_data): one result register;
// last marks the final result of a transaction.
// Sequencing: an arrival result goes through ST_EMIT0 to the output register;
// the next transaction is taken back in ST_IDLE. A tick whose running job
// continues passes through ST_RUN and ST_AGE and gives no result. Otherwise the
// best-candidate search ripples one cell per cycle through the cell row in
// ST_SCAN, then ST_START, ST_AGE, ST_EMIT0 and for a second result ST_EMIT1.
// One transaction is processed at a time; the next is taken once the results
// are handed to the output register.
// Reset clears all slots, the running job, the counters, and sets both
// configuration registers to 10. Configuration writes (cfg_we, cfg_idx,
// cfg_data) take effect at once and are to be made only while idle; the block
// does not check. A stalled output holds its result and the sequencer waits to
// load the next one; input stall stays high until the sequencer returns to idle.
`timescale 1ns / 1ps
module priority_scheduler_with_aging (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  psa_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_stall,
	output psa_pkg::res_t out_data,
	input  logic          cfg_we,
	input  logic          cfg_idx,
	input  logic [15:0]   cfg_data
);

	psa_pkg::cmd_t   cmd;
	psa_pkg::carry_t carry [psa_pkg::MAX_JOBS + 1];
	logic [psa_pkg::MAX_JOBS-1:0] cell_valid;

	assign carry[0] = '0;

	for (genvar i = 0; i < psa_pkg::MAX_JOBS; i++) begin : g_cell
		psa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.idx       (psa_pkg::SLOT_W'(i)),
			.cmd       (cmd),
			.carry_in  (carry[i]),
			.carry_out (carry[i+1]),
			.valid     (cell_valid[i])
		);
	end

	psa_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.cell_valid (cell_valid),
		.best       (carry[psa_pkg::MAX_JOBS]),
		.cmd        (cmd)
	);

endmodule

@@ dv/priority_scheduler_with_aging_tb.sv @@
// Self-checking testbench for the aging priority scheduler.
// Drives arrivals and ticks, predicts every result, and checks it field by field.
// Depends on psa_pkg and priority_scheduler_with_aging.
`timescale 1ns / 1ps
module priority_scheduler_with_aging_tb;

	localparam int NJOBS = psa_pkg::MAX_JOBS;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	psa_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	psa_pkg::res_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_idx = psa_pkg::CFG_AGE_INTERVAL;
	logic [15:0] cfg_data = '0;

	always #5 clk = ~clk;

	priority_scheduler_with_aging u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	// scheduler state mirror
	logic [15:0] sch_interval, sch_quantum;
	logic        slot_used [NJOBS];
	logic [15:0] slot_id [NJOBS];
	logic [6:0]  slot_pri [NJOBS];
	logic [15:0] slot_age [NJOBS];
	logic [15:0] slot_left [NJOBS];
	logic [15:0] slot_burst [NJOBS];
	logic [31:0] slot_arrive [NJOBS];
	logic [6:0]  slot_step [NJOBS];
	logic        run_on;
	int          run_slot;
	logic [15:0] quantum_cnt;
	logic [31:0] tick_cnt;

	psa_pkg::res_t expected_events[$];
	int errors = 0;
	int n_results = 0;
	int n_ticks = 0;
	int n_arrivals = 0;
	int send_idle = 0, recv_idle = 0;
	int step_n = 0;
	logic [2:0] step_first = psa_pkg::EV_ACCEPT;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp);
		$display("ERROR %0t: %s got %0h expected %0h", $time, what, got, exp);
		errors++;
	endtask

	function automatic psa_pkg::res_t make_event(input logic [2:0] ev,
			input logic [15:0] id, input logic [6:0] pri, input logic [31:0] ta,
			input logic [31:0] wt);
		psa_pkg::res_t r;
		r.event_res = ev; r.job_id_res = id; r.new_priority = pri;
		r.tick = tick_cnt; r.turnaround = ta; r.wait_res = wt; r.last = 1'b0;
		return r;
	endfunction

	function automatic void schedule_reset();
		sch_interval = 16'd10; sch_quantum = 16'd10;
		foreach (slot_used[s]) begin
			slot_used[s] = 1'b0; slot_id[s] = '0; slot_pri[s] = '0; slot_age[s] = '0;
			slot_left[s] = '0; slot_burst[s] = '0; slot_arrive[s] = '0; slot_step[s] = '0;
		end
		run_on = 1'b0; run_slot = 0; quantum_cnt = '0; tick_cnt = '0;
	endfunction

	// Advance the mirror by one transaction and queue its results.
	function automatic void schedule_step(input psa_pkg::req_t rq);
		psa_pkg::res_t r[$];
		int best, slot;
		logic [7:0] p;
		logic ok;
		if (rq.req_type == psa_pkg::REQ_ARRIVAL) begin
			ok = rq.burst != 0 && rq.priority_req >= psa_pkg::PRI_MIN &&
				rq.priority_req <= psa_pkg::PRI_MAX && rq.age_step != 0;
			slot = NJOBS;
			if (ok)
				for (int s = 0; s < NJOBS; s++)
					if (!slot_used[s]) begin
						slot = s;
						break;
					end
			if (slot >= NJOBS) begin
				r = {r, make_event(psa_pkg::EV_REJECT, rq.job_id, 7'd0, 32'd0, 32'd0)};
			end else begin
				slot_used[slot] = 1'b1; slot_id[slot] = rq.job_id;
				slot_pri[slot] = rq.priority_req; slot_age[slot] = '0;
				slot_left[slot] = rq.burst; slot_burst[slot] = rq.burst;
				slot_arrive[slot] = tick_cnt; slot_step[slot] = rq.age_step;
				r = {r, make_event(psa_pkg::EV_ACCEPT, rq.job_id, rq.priority_req,
					32'd0, 32'd0)};
			end
		end else begin
			quantum_cnt++;
			if (run_on) begin
				slot_left[run_slot]--;
				if (slot_left[run_slot] == 0) begin
					r = {r, make_event(psa_pkg::EV_TERM, slot_id[run_slot], 7'd0,
						tick_cnt - slot_arrive[run_slot],
						tick_cnt - slot_arrive[run_slot] - 32'(slot_burst[run_slot]))};
					slot_used[run_slot] = 1'b0; run_on = 1'b0; quantum_cnt = '0;
				end else if (sch_quantum != 0 && quantum_cnt == sch_quantum) begin
					p = {1'b0, slot_pri[run_slot]};
					p = (p > psa_pkg::DEMOTE_STEP + psa_pkg::PRI_MIN)
						? p - psa_pkg::DEMOTE_STEP : {1'b0, psa_pkg::PRI_MIN};
					slot_pri[run_slot] = p[6:0]; slot_age[run_slot] = '0;
					r = {r, make_event(psa_pkg::EV_DEMOTE, slot_id[run_slot], p[6:0],
						32'd0, 32'd0)};
					run_on = 1'b0; quantum_cnt = '0;
				end
			end
			if (!run_on) begin
				best = NJOBS;
				for (int s = 0; s < NJOBS; s++) begin
					if (!slot_used[s]) continue;
					if (best >= NJOBS || slot_pri[s] > slot_pri[best] ||
							(slot_pri[s] == slot_pri[best] && slot_id[s] < slot_id[best]))
						best = s;
				end
				if (best < NJOBS) begin
					run_on = 1'b1; run_slot = best; slot_age[best] = '0; quantum_cnt = '0;
					r = {r, make_event(psa_pkg::EV_RUN, slot_id[best], slot_pri[best],
						32'd0, 32'd0)};
				end else if (r.size() == 0) begin
					r = {r, make_event(psa_pkg::EV_IDLE, 16'd0, 7'd0, 32'd0, 32'd0)};
				end
			end
			for (int s = 0; s < NJOBS; s++) begin
				if (!slot_used[s] || (run_on && run_slot == s)) continue;
				slot_age[s]++;
				if (sch_interval != 0 && slot_age[s] == sch_interval) begin
					p = {1'b0, slot_pri[s]} + {1'b0, slot_step[s]};
					slot_age[s] = '0;
					slot_pri[s] = (p > {1'b0, psa_pkg::PRI_MAX}) ? psa_pkg::PRI_MAX : p[6:0];
				end
			end
			tick_cnt++;
		end
		if (r.size() > 0) r[r.size()-1].last = 1'b1;
		step_n = r.size();
		if (r.size() > 0) step_first = r[0].event_res;
		foreach (r[i]) expected_events = {expected_events, r[i]};
	endfunction

	// result checker and receiver stall
	always @(posedge clk) begin
		psa_pkg::res_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_results++;
				if (expected_events.size() == 0) begin
					report_mismatch("unexpected result event", 32'(out_data.event_res), 32'd0);
				end else begin
					e = expected_events.pop_front();
					if (out_data.event_res !== e.event_res)
						report_mismatch("event_res", 32'(out_data.event_res),
							32'(e.event_res));
					if (out_data.job_id_res !== e.job_id_res)
						report_mismatch("job_id_res", 32'(out_data.job_id_res),
							32'(e.job_id_res));
					if (out_data.new_priority !== e.new_priority)
						report_mismatch("new_priority", 32'(out_data.new_priority),
							32'(e.new_priority));
					if (out_data.tick !== e.tick)
						report_mismatch("tick", out_data.tick, e.tick);
					if (out_data.turnaround !== e.turnaround)
						report_mismatch("turnaround", out_data.turnaround, e.turnaround);
					if (out_data.wait_res !== e.wait_res)
						report_mismatch("wait_res", out_data.wait_res, e.wait_res);
					if (out_data.last !== e.last)
						report_mismatch("last", 32'(out_data.last), 32'(e.last));
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// The design raises its input stall after each transaction, so the
	// leading wait costs no throughput.
	task automatic send_item(input psa_pkg::req_t rq);
		@(posedge clk);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		in_valid <= 1'b1;
		in_data <= rq;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		schedule_step(rq);
		if (rq.req_type == psa_pkg::REQ_TICK) n_ticks++; else n_arrivals++;
		in_valid <= 1'b0;
	endtask

	task automatic drain_results();
		while (expected_events.size() != 0) @(posedge clk);
		repeat (NJOBS + 20) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == psa_pkg::CFG_AGE_INTERVAL) sch_interval = val; else sch_quantum = val;
	endtask

	function automatic psa_pkg::req_t arrival(input logic [15:0] id,
			input logic [15:0] b, input logic [6:0] p, input logic [6:0] st);
		psa_pkg::req_t rq;
		rq.req_type = psa_pkg::REQ_ARRIVAL; rq.job_id = id; rq.burst = b;
		rq.priority_req = p; rq.age_step = st;
		return rq;
	endfunction

	function automatic psa_pkg::req_t tick_req();
		psa_pkg::req_t rq;
		rq = '0;
		rq.req_type = psa_pkg::REQ_TICK;
		rq.job_id = 16'($urandom); rq.burst = 16'($urandom);
		rq.priority_req = 7'($urandom); rq.age_step = 7'($urandom);
		return rq;
	endfunction

	function automatic psa_pkg::req_t random_item(input int tick_pct);
		int k;
		k = $urandom_range(99);
		if (k < tick_pct) return tick_req();
		if (k < tick_pct + 4)
			return arrival(16'($urandom), $urandom_range(1) ? 16'd0 : 16'($urandom),
				$urandom_range(1) ? 7'($urandom_range(100, 127)) : 7'd0,
				$urandom_range(1) ? 7'd0 : 7'($urandom_range(1, 127)));
		return arrival(16'($urandom), ($urandom_range(9) == 0) ? 16'($urandom) :
			16'($urandom_range(1, 12)), 7'($urandom_range(1, 99)),
			7'($urandom_range(1, 127)));
	endfunction

	typedef struct {
		psa_pkg::req_t rq;
		logic check_first;
		logic [2:0] first_event;
	} stim_row_t;

	stim_row_t directed[$];

	initial begin
		stim_row_t row;
		schedule_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle tick, extremes, invalid fields, tie break, demote, terminate
		directed = '{
			'{tick_req(), 1'b1, psa_pkg::EV_IDLE},
			'{arrival(16'hFFFF, 16'd3, 7'd99, 7'd127), 1'b1, psa_pkg::EV_ACCEPT},
			'{arrival(16'h0000, 16'hFFFF, 7'd1, 7'd1), 1'b1, psa_pkg::EV_ACCEPT},
			'{arrival(16'h0005, 16'd0, 7'd50, 7'd5), 1'b1, psa_pkg::EV_REJECT},
			'{arrival(16'h0006, 16'd4, 7'd0, 7'd5), 1'b1, psa_pkg::EV_REJECT},
			'{arrival(16'h0007, 16'd4, 7'd100, 7'd5), 1'b1, psa_pkg::EV_REJECT},
			'{arrival(16'h0008, 16'd4, 7'd127, 7'd5), 1'b1, psa_pkg::EV_REJECT},
			'{arrival(16'h0009, 16'd4, 7'd40, 7'd0), 1'b1, psa_pkg::EV_REJECT},
			'{arrival(16'h0003, 16'd2, 7'd99, 7'd10), 1'b1, psa_pkg::EV_ACCEPT},
			'{tick_req(), 1'b1, psa_pkg::EV_RUN},
			'{tick_req(), 1'b0, psa_pkg::EV_ACCEPT},
			'{tick_req(), 1'b1, psa_pkg::EV_TERM},
			'{tick_req(), 1'b0, psa_pkg::EV_ACCEPT},
			'{tick_req(), 1'b0, psa_pkg::EV_ACCEPT},
			'{tick_req(), 1'b0, psa_pkg::EV_ACCEPT},
			'{arrival(16'h2AAA, 16'd30, 7'd21, 7'd64), 1'b1, psa_pkg::EV_ACCEPT},
			'{arrival(16'h5555, 16'd30, 7'd22, 7'd64), 1'b1, psa_pkg::EV_ACCEPT}
		};
		send_idle = 30; recv_idle = 53;
		foreach (directed[i]) begin
			row = directed[i];
			send_item(row.rq);
			if (row.check_first && (step_n == 0 || step_first !== row.first_event))
				report_mismatch("directed table event", 32'(step_first),
					32'(row.first_event));
		end
		repeat (25) send_item(tick_req());
		drain_results();

		// fill the table to force full rejects
		write_register(psa_pkg::CFG_TIME_QUANTUM, 16'd1);
		write_register(psa_pkg::CFG_AGE_INTERVAL, 16'd1);
		for (int i = 0; i < NJOBS + 3; i++)
			send_item(arrival(16'(i * 3), 16'd2, 7'($urandom_range(1, 99)), 7'd127));
		repeat (40) send_item(tick_req());
		drain_results();

		// random phases over several register settings, idling pattern rotates
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					write_register(psa_pkg::CFG_AGE_INTERVAL, 16'd0);
					write_register(psa_pkg::CFG_TIME_QUANTUM, 16'd0);
				end
				1: begin
					write_register(psa_pkg::CFG_AGE_INTERVAL, 16'hFFFF);
					write_register(psa_pkg::CFG_TIME_QUANTUM, 16'hFFFF);
				end
				2: begin
					write_register(psa_pkg::CFG_AGE_INTERVAL, 16'd3);
					write_register(psa_pkg::CFG_TIME_QUANTUM, 16'd2);
				end
				3: begin
					write_register(psa_pkg::CFG_AGE_INTERVAL, 16'($urandom_range(1, 8)));
					write_register(psa_pkg::CFG_TIME_QUANTUM, 16'($urandom_range(1, 6)));
				end
				4: begin
					write_register(psa_pkg::CFG_AGE_INTERVAL, 16'd2);
					write_register(psa_pkg::CFG_TIME_QUANTUM, 16'd1);
				end
				default: begin
					write_register(psa_pkg::CFG_AGE_INTERVAL, 16'd10);
					write_register(psa_pkg::CFG_TIME_QUANTUM, 16'd10);
				end
			endcase
			if (ph < 2) begin
				send_idle = 30; recv_idle = 53;
			end else if (ph < 4) begin
				send_idle = 53; recv_idle = 30;
			end else begin
				send_idle = 0; recv_idle = 0;
			end
			repeat (85) send_item(random_item(ph[0] ? 45 : 60));
			drain_results();
		end

		send_idle = 0; recv_idle = 0;
		drain_results();
		$display("Covered %0d arrivals and %0d ticks, %0d results checked,",
			n_arrivals, n_ticks, n_results);
		$display("with aging and quantum settings from zero to full scale.");
		if (errors == 0 && expected_events.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			if (expected_events.size() != 0)
				$display("ERROR: %0d results never arrived", expected_events.size());
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("ERROR: timeout");
		$display("Simulation FAILED");
		$finish;
	end

endmodule
